@@ hdl/ped_pkg.sv @@
// Shared constants, operation codes and the queued operation type of the event divider.
package ped_pkg;

  localparam int PATTERN_DEPTH  = 32;
  localparam int INTERVAL_WIDTH = 16;
  localparam int VALUE_W        = 32;
  localparam int MODE_W         = 2;
  localparam int IDX_W          = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PTR_W          = $clog2(PATTERN_DEPTH + 1);
  localparam int CNT_W          = INTERVAL_WIDTH + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_DATA    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_LOAD    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_RESTART = MODE_W'(2);

  localparam logic [VALUE_W-1:0] IV_MAX =
    VALUE_W'((64'd1 << INTERVAL_WIDTH) - 64'd1);
  localparam logic [INTERVAL_WIDTH-1:0] RESET_ENTRY  = INTERVAL_WIDTH'(2);
  localparam logic [INTERVAL_WIDTH-1:0] APPEND_ENTRY = INTERVAL_WIDTH'(1);

  typedef enum logic [1:0] {
    OP_DATA,
    OP_LOAD,
    OP_RESTART
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [VALUE_W-1:0]        value;
    logic [INTERVAL_WIDTH-1:0] iv;
    logic                      last;
  } ped_op_t;

endpackage

@@ hdl/ped_front.sv @@
// Front stage: accepts input items, decodes the mode and saturates intervals.
module ped_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [ped_pkg::MODE_W-1:0]     mode,
  input  logic [ped_pkg::VALUE_W-1:0]    value,
  input  logic                           last_entry,
  output logic                           op_valid,
  input  logic                           op_stall,
  output ped_pkg::ped_op_t               op
);
  import ped_pkg::*;

  logic    keep;
  ped_op_t dec;

  always_comb begin
    keep      = 1'b1;
    dec.kind  = OP_DATA;
    dec.value = value;
    dec.last  = last_entry;
    dec.iv    = (value > IV_MAX) ? '1 : value[INTERVAL_WIDTH-1:0];
    case (mode)
      MODE_DATA:    dec.kind = OP_DATA;
      MODE_LOAD:    dec.kind = OP_LOAD;
      MODE_RESTART: dec.kind = OP_RESTART;
      default:      keep = 1'b0;  // unused mode: dropped here
    endcase
  end

  assign item_stall = op_valid && op_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (!item_stall) begin
      op_valid <= item_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      op <= dec;
    end
  end

endmodule

@@ hdl/ped_queue.sv @@
// Short FIFO of decoded operations between the front and back stages.
module ped_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  ped_pkg::ped_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_stall,
  output ped_pkg::ped_op_t pop_op
);
  import ped_pkg::*;

  ped_op_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign push_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    bump = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

@@ hdl/ped_back.sv @@
// Back stage: interval store, beat and tick counters, result register.
module ped_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_valid,
  output logic                                op_stall,
  input  ped_pkg::ped_op_t                    op,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [ped_pkg::VALUE_W-1:0]         passed_value,
  output logic                                pattern_end
);
  import ped_pkg::*;

  logic [INTERVAL_WIDTH-1:0] store [PATTERN_DEPTH];
  logic [PTR_W-1:0]          pattern_length, pattern_length_next;
  logic [IDX_W-1:0]          beat_index, beat_index_next;
  logic [CNT_W-1:0]          tick_count, tick_count_next;
  logic [PTR_W-1:0]          load_pointer, load_pointer_next;

  logic                      go;
  logic [IDX_W-1:0]          rd_addr;
  logic [INTERVAL_WIDTH-1:0] rd_data;
  logic                      we_a, we_b;
  logic [IDX_W-1:0]          wa_addr, wb_addr;
  logic                      pass, pass_end;
  logic [CNT_W-1:0]          tick_inc;
  logic [PTR_W-1:0]          beat_inc;
  logic                      has_room, append;
  logic [PTR_W-1:0]          n_len, new_len;
  logic [INTERVAL_WIDTH-1:0] e_last;

  // tick value that makes the next data item pass on an entry
  function automatic logic [CNT_W-1:0] arm_tick(input logic [INTERVAL_WIDTH-1:0] e);
    arm_tick = (e == '0) ? '0 : CNT_W'(e) - CNT_W'(1);
  endfunction

  assign op_stall = result_valid && result_stall;
  assign go       = op_valid && !op_stall;
  assign rd_data  = store[rd_addr];

  always_comb begin
    rd_addr             = beat_index;
    pattern_length_next = pattern_length;
    beat_index_next     = beat_index;
    tick_count_next     = tick_count;
    load_pointer_next   = load_pointer;
    we_a     = 1'b0;
    we_b     = 1'b0;
    wa_addr  = load_pointer[IDX_W-1:0];
    wb_addr  = '0;
    pass     = 1'b0;
    pass_end = 1'b0;
    tick_inc = tick_count + CNT_W'(1);
    beat_inc = PTR_W'(beat_index) + PTR_W'(1);
    has_room = (load_pointer < PTR_W'(PATTERN_DEPTH));
    n_len    = has_room ? load_pointer + PTR_W'(1) : load_pointer;
    e_last   = '0;
    append   = 1'b0;
    new_len  = n_len;
    case (op.kind)
      OP_DATA: begin
        rd_addr = beat_index;
        if (rd_data != '0) begin
          if (tick_inc == CNT_W'(rd_data)) begin
            pass            = 1'b1;
            pass_end        = (PTR_W'(beat_index) == pattern_length - PTR_W'(1));
            tick_count_next = '0;
            beat_index_next = (beat_inc >= pattern_length) ? '0 : IDX_W'(beat_inc);
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      OP_LOAD: begin
        rd_addr = IDX_W'(PATTERN_DEPTH - 1);
        we_a    = has_room;
        // the final entry is the one written now, unless the store is full
        e_last  = has_room ? op.iv : rd_data;
        append  = (e_last == '0) && (n_len < PTR_W'(PATTERN_DEPTH));
        new_len = append ? n_len + PTR_W'(1) : n_len;
        wb_addr = IDX_W'(n_len);
        if (op.last) begin
          we_b                = append;
          pattern_length_next = new_len;
          beat_index_next     = IDX_W'(new_len - PTR_W'(1));
          tick_count_next     = append ? '0 : arm_tick(e_last);
          load_pointer_next   = '0;
        end else begin
          load_pointer_next = n_len;
        end
      end
      OP_RESTART: begin
        rd_addr           = IDX_W'(pattern_length - PTR_W'(1));
        beat_index_next   = rd_addr;
        tick_count_next   = arm_tick(rd_data);
        load_pointer_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PTR_W'(1);
      beat_index     <= '0;
      tick_count     <= CNT_W'(1);
      load_pointer   <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (go) begin
        pattern_length <= pattern_length_next;
        beat_index     <= beat_index_next;
        tick_count     <= tick_count_next;
        load_pointer   <= load_pointer_next;
      end
      if (go && pass)         result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && pass) begin
      passed_value <= op.value;
      pattern_end  <= pass_end;
    end
  end

  // store: only entry zero has a reset value
  always_ff @(posedge clk) begin
    if (go && we_a) store[wa_addr] <= op.iv;
    if (go && we_b) store[wb_addr] <= APPEND_ENTRY;
    if (rst)        store[0]       <= RESET_ENTRY;
  end

endmodule

@@ hdl/pattern_event_divider_core.sv @@
// Pattern event divider: passes every Nth data item, N taken in turn from a stored pattern.
// Path: a passing data item goes through the front register, a queue slot and the result
//   register before its result shows.
// Throughput: one item per cycle; each item costs one back-stage step (one store read,
//   one 17-bit increment and compare). The back halts while a result waits stalled; the
//   queue lets the front keep taking items until both slots are full.
// Reset (rst, synchronous): pattern of one entry of 2, beat 0, tick 1, load pointer 0,
//   queue and result register empty. Other store entries hold no defined value until loaded.
module pattern_event_divider_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [ped_pkg::MODE_W-1:0]  mode,
  input  logic [ped_pkg::VALUE_W-1:0] value,
  input  logic                        last_entry,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [ped_pkg::VALUE_W-1:0] passed_value,
  output logic                        pattern_end
);
  import ped_pkg::*;

  // front -> queue
  logic    f_valid, f_stall;
  ped_op_t f_op;
  // queue -> back
  logic    q_valid, q_stall;
  ped_op_t q_op;

  // Front decodes the mode; mode 3 items are accepted and dropped there.
  ped_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .value      (value),
    .last_entry (last_entry),
    .op_valid   (f_valid),
    .op_stall   (f_stall),
    .op         (f_op)
  );

  // Two-slot queue decouples front from back.
  ped_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_op     (q_op)
  );

  // Back executes data, load and restart operations in order.
  // It halts only while the result register is full and stalled.
  ped_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op_stall     (q_stall),
    .op           (q_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .passed_value (passed_value),
    .pattern_end  (pattern_end)
  );

endmodule
